FILE: rtl/gdsii_record_deframer_top_macros.svh
// assertion macros for the gdsii record deframer
`ifndef GDSII_RECORD_DEFRAMER_TOP_MACROS_SVH
`define GDSII_RECORD_DEFRAMER_TOP_MACROS_SVH

// same-cycle implication, held off during reset
`define GDRD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define GDRD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/gdrd_pkg.sv
// shared types and constants for the gdsii record deframer
`timescale 1ns / 1ps
package gdrd_pkg;

    localparam int DEF_OFFSET_WIDTH = 40;
    localparam int OUT_OFFSET_W     = 40;
    localparam int CFG_SIZE_W       = 40;
    localparam int APB_DATA_W       = 64;
    localparam int APB_ADDR_W       = 4;
    localparam int REG_SEL_BIT      = 3;

    localparam logic REG_STREAM_SIZE = 1'b0;

    localparam logic [15:0] HDR_BYTES = 16'd4;
    localparam logic [15:0] PAD_BYTES = 16'd2;

    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;
    localparam logic [1:0] KIND_PADDING = 2'd3;

    localparam logic [2:0] FAULT_NONE      = 3'd0;
    localparam logic [2:0] FAULT_TRUNCATED = 3'd1;
    localparam logic [2:0] FAULT_SHORT_LEN = 3'd2;
    localparam logic [2:0] FAULT_ODD_LEN   = 3'd3;
    localparam logic [2:0] FAULT_OVERRUN   = 3'd4;

    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_HALT    = 2'd2;

    typedef struct packed {
        logic [1:0]              item_kind;
        logic [OUT_OFFSET_W-1:0] record_offset;
        logic [15:0]             record_length;
        logic [7:0]              record_kind;
        logic [7:0]              payload_format;
        logic [7:0]              payload_value;
        logic                    last_of_record;
        logic                    last_of_stream;
        logic [2:0]              fault_code;
    } t_result;

endpackage

FILE: rtl/gdrd_apb_regs.sv
// apb register file holding the stream size
`timescale 1ns / 1ps
module gdrd_apb_regs
    import gdrd_pkg::*;
#(
    parameter int OFFSET_WIDTH = DEF_OFFSET_WIDTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_ADDR_W-1:0]   paddr,
    input  logic [APB_DATA_W-1:0]   pwdata,
    output logic [APB_DATA_W-1:0]   prdata,
    output logic                    pready,
    output logic [OFFSET_WIDTH-1:0] o_stream_size
);

    logic [OFFSET_WIDTH-1:0] r_stream_size;
    logic                    wr_en;
    logic                    sel_size;

    assign pready   = 1'b1;
    assign sel_size = (paddr[REG_SEL_BIT] == REG_STREAM_SIZE);
    assign wr_en    = psel && penable && pwrite && pready && sel_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stream_size <= '0;
        end else if (wr_en) begin
            r_stream_size <= OFFSET_WIDTH'(pwdata[CFG_SIZE_W-1:0]);
        end
    end

    assign prdata        = sel_size ? APB_DATA_W'(r_stream_size) : '0;
    assign o_stream_size = r_stream_size;

endmodule

FILE: rtl/gdrd_in_stage.sv
// input register for incoming stream bytes
`timescale 1ns / 1ps
module gdrd_in_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_data_byte,
    input  logic       i_take,
    output logic       o_stall,
    output logic       o_valid,
    output logic [7:0] o_data
);

    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_data;
    logic       accept;

    assign o_stall = r_valid && !i_take;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_data <= i_data_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: rtl/gdrd_parser.sv
// record parser state and per-byte decode
`timescale 1ns / 1ps
module gdrd_parser
    import gdrd_pkg::*;
#(
    parameter int OFFSET_WIDTH = DEF_OFFSET_WIDTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic [7:0]              i_data,
    input  logic                    i_out_free,
    input  logic [OFFSET_WIDTH-1:0] i_stream_size,
    output logic                    o_take,
    output logic                    o_res_valid,
    output t_result                 o_res
);

    logic [OFFSET_WIDTH-1:0] r_pos, n_pos;
    logic [OFFSET_WIDTH-1:0] r_record_start, n_record_start;
    logic [23:0]             r_hs, n_hs;
    logic [15:0]             r_bir, n_bir;
    logic [15:0]             r_cur_len, n_cur_len;
    logic [1:0]              r_phase, n_phase;

    logic [OFFSET_WIDTH-1:0] rs;
    logic [OFFSET_WIDTH-1:0] remaining;
    logic [OFFSET_WIDTH-1:0] next_pos;
    logic [63:0]             rs_wide;
    logic [15:0]             len_hdr;
    logic [15:0]             bir_inc;
    logic                    last_pay;

    assign o_take = i_valid && i_out_free;

    always_comb begin
        rs        = (r_bir == '0) ? r_pos : r_record_start;
        remaining = (i_stream_size > rs) ? (i_stream_size - rs) : '0;
        next_pos  = r_pos + OFFSET_WIDTH'(1);
        rs_wide   = 64'(rs);
        len_hdr   = r_hs[23:8];
        bir_inc   = r_bir + 16'd1;
        last_pay  = (bir_inc >= r_cur_len);

        n_pos          = r_pos;
        n_record_start = r_record_start;
        n_hs           = r_hs;
        n_bir          = r_bir;
        n_cur_len      = r_cur_len;
        n_phase        = r_phase;

        o_res_valid         = 1'b0;
        o_res               = '0;
        o_res.record_offset = rs_wide[OUT_OFFSET_W-1:0];

        if (o_take) begin
            case (r_phase)
                PH_PAYLOAD: begin
                    n_pos                = next_pos;
                    n_bir                = last_pay ? 16'd0 : bir_inc;
                    n_phase              = last_pay ? PH_HEADER : PH_PAYLOAD;
                    o_res_valid          = 1'b1;
                    o_res.item_kind      = KIND_PAYLOAD;
                    o_res.record_length  = r_cur_len;
                    o_res.record_kind    = r_hs[15:8];
                    o_res.payload_format = r_hs[7:0];
                    o_res.payload_value  = i_data;
                    o_res.last_of_record = last_pay;
                    o_res.last_of_stream = (next_pos == i_stream_size);
                end
                PH_HEADER: begin
                    if (!(r_bir == '0 && r_pos >= i_stream_size)) begin
                        n_record_start = rs;
                        if (remaining < OFFSET_WIDTH'(HDR_BYTES)) begin
                            if (remaining == OFFSET_WIDTH'(PAD_BYTES) && r_bir == 16'd0) begin
                                n_hs  = 24'(i_data);
                                n_bir = 16'd1;
                                n_pos = next_pos;
                            end else if (remaining == OFFSET_WIDTH'(PAD_BYTES) &&
                                         r_bir == 16'd1 && r_hs == '0 && i_data == '0) begin
                                n_pos                = next_pos;
                                n_bir                = 16'd0;
                                n_hs                 = '0;
                                o_res_valid          = 1'b1;
                                o_res.item_kind      = KIND_PADDING;
                                o_res.last_of_stream = 1'b1;
                            end else begin
                                n_phase          = PH_HALT;
                                o_res_valid      = 1'b1;
                                o_res.item_kind  = KIND_ERROR;
                                o_res.fault_code = FAULT_TRUNCATED;
                            end
                        end else begin
                            n_pos = next_pos;
                            if (r_bir < (HDR_BYTES - 16'd1)) begin
                                n_hs  = {r_hs[15:0], i_data};
                                n_bir = bir_inc;
                            end else if (len_hdr < HDR_BYTES) begin
                                n_phase          = PH_HALT;
                                o_res_valid      = 1'b1;
                                o_res.item_kind  = KIND_ERROR;
                                o_res.fault_code = FAULT_SHORT_LEN;
                            end else if (len_hdr[0]) begin
                                n_phase          = PH_HALT;
                                o_res_valid      = 1'b1;
                                o_res.item_kind  = KIND_ERROR;
                                o_res.fault_code = FAULT_ODD_LEN;
                            end else if (OFFSET_WIDTH'(len_hdr) > remaining) begin
                                n_phase          = PH_HALT;
                                o_res_valid      = 1'b1;
                                o_res.item_kind  = KIND_ERROR;
                                o_res.fault_code = FAULT_OVERRUN;
                            end else begin
                                n_cur_len            = len_hdr;
                                n_hs                 = {8'd0, r_hs[7:0], i_data};
                                n_bir                = (len_hdr == HDR_BYTES) ? 16'd0 : HDR_BYTES;
                                n_phase              = (len_hdr == HDR_BYTES) ? PH_HEADER
                                                                              : PH_PAYLOAD;
                                o_res_valid          = 1'b1;
                                o_res.item_kind      = KIND_HEADER;
                                o_res.record_length  = len_hdr;
                                o_res.record_kind    = r_hs[7:0];
                                o_res.payload_format = i_data;
                                o_res.last_of_record = (len_hdr == HDR_BYTES);
                                o_res.last_of_stream = (len_hdr == HDR_BYTES) &&
                                                       (next_pos == i_stream_size);
                            end
                        end
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos          <= '0;
            r_record_start <= '0;
            r_hs           <= '0;
            r_bir          <= '0;
            r_cur_len      <= '0;
            r_phase        <= PH_HEADER;
        end else begin
            r_pos          <= n_pos;
            r_record_start <= n_record_start;
            r_hs           <= n_hs;
            r_bir          <= n_bir;
            r_cur_len      <= n_cur_len;
            r_phase        <= n_phase;
        end
    end

endmodule

FILE: rtl/gdrd_out_stage.sv
// result register toward the output channel
`timescale 1ns / 1ps
module gdrd_out_stage
    import gdrd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    input  logic    i_stall,
    output logic    o_free,
    output logic    o_valid,
    output t_result o_res
);

    logic    r_valid;
    logic    n_valid;
    t_result r_res;

    assign o_free = !r_valid || !i_stall;

    always_comb begin
        n_valid = r_valid;
        if (o_free) begin
            n_valid = i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

FILE: rtl/gdsii_record_deframer_top.sv
// top level of the gdsii record deframer
`timescale 1ns / 1ps
// Takes one stream byte per cycle while the output is not stalled and returns
// at most one result per byte: a header result when the fourth header byte
// arrives, one result per payload byte, a padding result for two zero bytes
// exactly at the stream end, or one error result after which every byte is
// dropped until reset. A byte passes through an input register and the parser
// decode into a result register, so a result is registered when the parser
// takes its byte; the sustained rate is one byte per cycle and only output
// stall slows it. Bytes that arrive after the stream end and the first three
// bytes of each header are consumed without a result. The stream size register
// lies at byte addresses 0 to 7 and must be written while no byte is in flight.
`include "gdsii_record_deframer_top_macros.svh"
module gdsii_record_deframer_top
    import gdrd_pkg::*;
#(
    parameter int OFFSET_WIDTH = DEF_OFFSET_WIDTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_ADDR_W-1:0]   paddr,
    input  logic [APB_DATA_W-1:0]   pwdata,
    output logic [APB_DATA_W-1:0]   prdata,
    output logic                    pready,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [7:0]              i_data_byte,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [1:0]              o_item_kind,
    output logic [OUT_OFFSET_W-1:0] o_record_offset,
    output logic [15:0]             o_record_length,
    output logic [7:0]              o_record_kind,
    output logic [7:0]              o_payload_format,
    output logic [7:0]              o_payload_value,
    output logic                    o_last_of_record,
    output logic                    o_last_of_stream,
    output logic [2:0]              o_fault_code
);

    logic [OFFSET_WIDTH-1:0] stream_size;
    logic                    in_valid;
    logic [7:0]              in_data;
    logic                    take;
    logic                    out_free;
    logic                    res_valid;
    t_result                 res;
    t_result                 out_res;

    gdrd_apb_regs #(
        .OFFSET_WIDTH(OFFSET_WIDTH)
    ) u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_stream_size (stream_size)
    );

    gdrd_in_stage u_in (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data_byte (i_data_byte),
        .i_take      (take),
        .o_stall     (o_stall),
        .o_valid     (in_valid),
        .o_data      (in_data)
    );

    gdrd_parser #(
        .OFFSET_WIDTH(OFFSET_WIDTH)
    ) u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (in_valid),
        .i_data        (in_data),
        .i_out_free    (out_free),
        .i_stream_size (stream_size),
        .o_take        (take),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    gdrd_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_valid),
        .i_res   (res),
        .i_stall (i_stall),
        .o_free  (out_free),
        .o_valid (o_valid),
        .o_res   (out_res)
    );

    assign o_item_kind      = out_res.item_kind;
    assign o_record_offset  = out_res.record_offset;
    assign o_record_length  = out_res.record_length;
    assign o_record_kind    = out_res.record_kind;
    assign o_payload_format = out_res.payload_format;
    assign o_payload_value  = out_res.payload_value;
    assign o_last_of_record = out_res.last_of_record;
    assign o_last_of_stream = out_res.last_of_stream;
    assign o_fault_code     = out_res.fault_code;

    `GDRD_ASSERT_SAME(a_error_has_code, i_clk, i_rst_n, o_valid && o_item_kind == KIND_ERROR, o_fault_code != FAULT_NONE, "error item without fault code")
    `GDRD_ASSERT_NEXT(a_halt_after_error, i_clk, i_rst_n, o_valid && !i_stall && o_item_kind == KIND_ERROR, !o_valid, "item delivered after an error")
    `GDRD_ASSERT_SAME(a_padding_ends_stream, i_clk, i_rst_n, o_valid && o_item_kind == KIND_PADDING, o_last_of_stream && !o_last_of_record, "padding item not at stream end")
    `GDRD_ASSERT_SAME(a_stall_needs_full_input, i_clk, i_rst_n, o_stall, in_valid && !out_free, "input stalled with room to advance")

endmodule

FILE: bench/gdsii_record_deframer_top_test.sv
// self-checking testbench for the gdsii record deframer: random record streams, checked per result
`timescale 1ns / 1ps
module gdsii_record_deframer_top_test;
    import gdrd_pkg::*;

    localparam int QUIET_LIMIT = 5000;
    localparam logic [APB_ADDR_W-1:0] SIZE_ADDR =
        {{(APB_ADDR_W-1){1'b0}}, REG_STREAM_SIZE} << REG_SEL_BIT;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [7:0] i_data_byte = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic [1:0] o_item_kind;
    logic [OUT_OFFSET_W-1:0] o_record_offset;
    logic [15:0] o_record_length;
    logic [7:0] o_record_kind;
    logic [7:0] o_payload_format;
    logic [7:0] o_payload_value;
    logic o_last_of_record;
    logic o_last_of_stream;
    logic [2:0] o_fault_code;

    gdsii_record_deframer_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_valid(i_valid), .o_stall(o_stall), .i_data_byte(i_data_byte),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_item_kind(o_item_kind), .o_record_offset(o_record_offset),
        .o_record_length(o_record_length), .o_record_kind(o_record_kind),
        .o_payload_format(o_payload_format), .o_payload_value(o_payload_value),
        .o_last_of_record(o_last_of_record), .o_last_of_stream(o_last_of_stream),
        .o_fault_code(o_fault_code)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [7:0] pending_bytes[$];
    t_result expected_results[$];
    int unsigned pushed_cnt = 0;
    int unsigned accepted_cnt = 0;
    int unsigned mismatches = 0;
    int unsigned size_writes = 0;
    int unsigned headers_seen = 0;
    int unsigned payload_seen = 0;
    int unsigned padding_seen = 0;
    int unsigned errors_seen = 0;
    logic [2:0] fault_seen = FAULT_NONE;
    int gap_left = 0;
    int stall_left = 0;
    int backpressure_left = 0;
    bit backpressure_req = 0;
    bit backpressure_taken = 0;
    bit calm = 0;
    int quiet_cycles = 0;

    logic [39:0] m_size = '0;
    logic [39:0] m_pos = '0;
    logic [39:0] m_rec_start = '0;
    logic [23:0] m_hdr = '0;
    logic [15:0] m_count = '0;
    logic [15:0] m_len = '0;
    logic [1:0] m_phase = PH_HEADER;

    function automatic bit deframe_byte(input logic [7:0] b, output t_result r);
        logic [39:0] room;
        logic [15:0] hdr_len;
        logic tail;
        r = '0;
        if (m_phase == PH_HALT) return 1'b0;
        if (m_phase == PH_PAYLOAD) begin
            m_pos = m_pos + 40'd1;
            m_count = m_count + 16'd1;
            tail = (m_count >= m_len);
            if (tail) m_phase = PH_HEADER;
            r.item_kind = KIND_PAYLOAD;
            r.record_offset = m_rec_start;
            r.record_length = m_len;
            r.record_kind = m_hdr[15:8];
            r.payload_format = m_hdr[7:0];
            r.payload_value = b;
            r.last_of_record = tail;
            r.last_of_stream = (m_pos == m_size);
            if (tail) m_count = '0;
            return 1'b1;
        end
        if (m_count == 0) begin
            if (m_pos >= m_size) return 1'b0;
            m_rec_start = m_pos;
        end
        room = (m_size > m_rec_start) ? m_size - m_rec_start : '0;
        r.record_offset = m_rec_start;
        if (room < 40'(HDR_BYTES)) begin
            if (room == 40'(PAD_BYTES) && m_count == 0) begin
                m_hdr = {16'd0, b};
                m_count = 16'd1;
                m_pos = m_pos + 40'd1;
                return 1'b0;
            end
            if (room == 40'(PAD_BYTES) && m_count == 1 && m_hdr == 0 && b == 0) begin
                m_pos = m_pos + 40'd1;
                m_count = '0;
                m_hdr = '0;
                r.item_kind = KIND_PADDING;
                r.last_of_stream = 1'b1;
                return 1'b1;
            end
            m_phase = PH_HALT;
            r.item_kind = KIND_ERROR;
            r.fault_code = FAULT_TRUNCATED;
            return 1'b1;
        end
        m_pos = m_pos + 40'd1;
        if (m_count < HDR_BYTES - 16'd1) begin
            m_hdr = {m_hdr[15:0], b};
            m_count = m_count + 16'd1;
            return 1'b0;
        end
        hdr_len = m_hdr[23:8];
        if (hdr_len < HDR_BYTES) r.fault_code = FAULT_SHORT_LEN;
        else if (hdr_len[0]) r.fault_code = FAULT_ODD_LEN;
        else if (40'(hdr_len) > room) r.fault_code = FAULT_OVERRUN;
        if (r.fault_code != FAULT_NONE) begin
            m_phase = PH_HALT;
            r.item_kind = KIND_ERROR;
            return 1'b1;
        end
        m_len = hdr_len;
        r.item_kind = KIND_HEADER;
        r.record_length = hdr_len;
        r.record_kind = m_hdr[7:0];
        r.payload_format = b;
        r.last_of_record = (hdr_len == HDR_BYTES);
        r.last_of_stream = (hdr_len == HDR_BYTES) && (m_pos == m_size);
        m_hdr = {8'd0, m_hdr[7:0], b};
        if (hdr_len == HDR_BYTES) begin
            m_count = '0;
            m_phase = PH_HEADER;
        end else begin
            m_count = HDR_BYTES;
            m_phase = PH_PAYLOAD;
        end
        return 1'b1;
    endfunction

    function automatic int next_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
        if (want !== got) begin
            $error("%s expected %0h actual %0h", name, want, got);
            mismatches++;
        end
    endtask

    // byte driver
    always @(posedge i_clk) begin : drv
        t_result res;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_data_byte <= '0;
        end else begin
            if (i_valid && !o_stall) begin
                accepted_cnt++;
                if (deframe_byte(i_data_byte, res)) expected_results.push_back(res);
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pending_bytes.size() != 0) begin
                    i_valid <= 1'b1;
                    i_data_byte <= pending_bytes.pop_front();
                    gap_left = next_gap();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and output stall
    always @(posedge i_clk) begin : mon
        t_result want;
        int r;
        logic stall_nxt;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result with nothing expected, item_kind %0d", o_item_kind);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("item_kind", 64'(want.item_kind), 64'(o_item_kind));
                    check_field("record_offset", 64'(want.record_offset),
                                64'(o_record_offset));
                    check_field("record_length", 64'(want.record_length),
                                64'(o_record_length));
                    check_field("record_kind", 64'(want.record_kind), 64'(o_record_kind));
                    check_field("payload_format", 64'(want.payload_format),
                                64'(o_payload_format));
                    check_field("payload_value", 64'(want.payload_value),
                                64'(o_payload_value));
                    check_field("last_of_record", 64'(want.last_of_record),
                                64'(o_last_of_record));
                    check_field("last_of_stream", 64'(want.last_of_stream),
                                64'(o_last_of_stream));
                    check_field("fault_code", 64'(want.fault_code), 64'(o_fault_code));
                end
                case (o_item_kind)
                    KIND_HEADER: headers_seen++;
                    KIND_PAYLOAD: payload_seen++;
                    KIND_PADDING: padding_seen++;
                    default: begin
                        errors_seen++;
                        fault_seen = o_fault_code;
                    end
                endcase
            end
            if (backpressure_req && !backpressure_taken) begin
                backpressure_taken = 1;
                backpressure_left = 300;
            end
            if (backpressure_left > 0) begin
                backpressure_left--;
                stall_nxt = 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                stall_nxt = 1'b1;
            end else if (calm) begin
                stall_nxt = 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                stall_nxt = (r >= 75);
                if (r >= 95) stall_left = $urandom_range(10, 50);
                else if (r >= 75) stall_left = $urandom_range(0, 3);
            end
            i_stall <= stall_nxt;
        end
    end

    // watchdog on cycles with no transfer anywhere
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_size(input logic [39:0] v);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= SIZE_ADDR;
        pwdata <= 64'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        m_size = v;
        size_writes++;
        @(negedge i_clk);
    endtask

    task automatic settle();
        do @(posedge i_clk);
        while (accepted_cnt != pushed_cnt || expected_results.size() != 0);
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic push_byte(input logic [7:0] b);
        pending_bytes.push_back(b);
        pushed_cnt++;
    endtask

    task automatic push_junk(input int n);
        repeat (n) push_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic push_record(input int len, input logic [7:0] rk, input logic [7:0] fmt);
        logic [15:0] l16;
        l16 = 16'(len);
        push_byte(l16[15:8]);
        push_byte(l16[7:0]);
        push_byte(rk);
        push_byte(fmt);
        repeat (len - 4) push_byte(8'($urandom_range(0, 255)));
    endtask

    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return 2 * $urandom_range(2, 20);
        if (r < 97) return 2 * $urandom_range(21, 150);
        return 2 * $urandom_range(151, 400);
    endfunction

    task automatic random_phase(input bit squeeze);
        int lens[$];
        int total;
        int pick;
        bit pad;
        total = 0;
        pad = 0;
        calm = squeeze || ($urandom_range(0, 4) == 0);
        if (squeeze) lens.push_back(400);
        else repeat ($urandom_range(1, 6)) lens.push_back(pick_length());
        foreach (lens[k]) total += lens[k];
        pick = $urandom_range(0, 11);
        if (pick == 0) begin
            write_size('0);
            push_junk(2);
            settle();
        end
        if (pick == 1) begin
            write_size('1);
        end else begin
            pad = ($urandom_range(0, 3) == 0);
            write_size(m_pos + 40'(total) + (pad ? 40'd2 : 40'd0));
        end
        if (squeeze) backpressure_req = 1;
        foreach (lens[k]) begin
            push_record(lens[k], 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end
        if (pad) begin
            push_byte(8'h00);
            push_byte(8'h00);
        end
        if (pick != 1 && $urandom_range(0, 3) == 0) push_junk($urandom_range(1, 5));
        settle();
    endtask

    // the stream ends on one malformed record, since only reset clears the halt
    task automatic fault_phase();
        logic [39:0] start;
        logic [7:0] b0;
        logic [7:0] b1;
        calm = 0;
        start = m_pos;
        case ($urandom_range(0, 5))
            0: begin
                write_size(start + (($urandom_range(0, 1) == 0) ? 40'd1 : 40'd3));
                push_junk(3);
            end
            1: begin
                b0 = 8'($urandom_range(0, 255));
                b1 = 8'($urandom_range(0, 255));
                if (b0 == 0 && b1 == 0) b1 = 8'h01;
                write_size(start + 40'd2);
                push_byte(b0);
                push_byte(b1);
            end
            2: begin
                write_size(start + 40'd100);
                push_record(0, 8'h00, 8'h00);
                pending_bytes[pending_bytes.size() - 3] = 8'($urandom_range(0, 3));
            end
            3: begin
                write_size(start + 40'd100);
                push_record(2 * $urandom_range(2, 40) + 1, 8'h10, 8'h02);
            end
            4: begin
                write_size(start + 40'd20);
                push_record(($urandom_range(0, 1) == 0) ? 16'hFFFE : 22, 8'h05, 8'h06);
            end
            default: begin
                write_size(start + 40'd100);
                push_byte(8'h00);
                push_byte(8'h08);
                settle();
                write_size(start + 40'd3);
                push_byte(8'h0D);
            end
        endcase
        push_junk(20);
        settle();
    endtask

    initial begin
        logic [39:0] start;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // no stream yet: bytes are dropped
        push_junk(3);
        settle();
        write_size('0);
        push_junk(2);
        settle();

        // open-ended stream with extreme field values
        write_size('1);
        push_record(4, 8'hFF, 8'h00);
        push_byte(8'h00); push_byte(8'h06); push_byte(8'h00); push_byte(8'hFF);
        push_byte(8'h00); push_byte(8'hFF);
        settle();

        // stream ending on a header-only record, then bytes past the end
        write_size(m_pos + 40'd10);
        push_record(6, 8'h01, 8'h02);
        push_record(4, 8'h11, 8'h00);
        push_junk(3);
        settle();

        // two zero bytes of padding at the end
        write_size(m_pos + 40'd12);
        push_record(10, 8'h03, 8'h05);
        push_byte(8'h00);
        push_byte(8'h00);
        settle();

        // size raised while a record is in its payload
        start = m_pos;
        write_size(start + 40'd8);
        push_byte(8'h00); push_byte(8'h08); push_byte(8'h08); push_byte(8'h03);
        push_byte(8'hA5);
        settle();
        write_size(start + 40'd20);
        push_byte(8'h5A);
        push_byte(8'hC3);
        push_byte(8'h3C);
        push_record(12, 8'h0C, 8'h01);
        settle();

        for (int n = 0; pushed_cnt < 1800; n++) random_phase(n == 0);
        fault_phase();

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            $error("%0d expected results never arrived", expected_results.size());
            mismatches++;
        end
        $display("offered %0d bytes across %0d stream size settings", pushed_cnt, size_writes);
        $display("saw %0d headers, %0d payload bytes, %0d paddings, %0d errors (fault %0d)",
                 headers_seen, payload_seen, padding_seen, errors_seen, fault_seen);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/gdrd_pkg.sv
rtl/gdrd_apb_regs.sv
rtl/gdrd_in_stage.sv
rtl/gdrd_parser.sv
rtl/gdrd_out_stage.sv
rtl/gdsii_record_deframer_top.sv
bench/gdsii_record_deframer_top_test.sv
